// File: src/mtf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared constants and types of the move-to-front byte coder.
// ----------------------------------------------------------------------------
package mtf_pkg;

  localparam int unsigned ALPHABET_SIZE = 256;
  localparam int unsigned SYM_W         = 8;
  localparam int unsigned IDX_W         = $clog2(ALPHABET_SIZE);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_WALK,
    ST_FRONT
  } mtf_state_e;

  typedef struct packed {
    logic load;
    logic prime;
    logic walk;
    logic front;
  } mtf_cmd_t;

  typedef struct packed {
    logic hit;
  } mtf_status_t;

endpackage

// File: src/mtf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_ctrl
// Controller: sequences load, list walk and front write for one item and
// owns the input and output handshakes.
// ----------------------------------------------------------------------------
module mtf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mtf_pkg::mtf_cmd_t    cmd_o,
  input  mtf_pkg::mtf_status_t status_i
);
  import mtf_pkg::*;

  mtf_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PRIME;
        end
      end
      ST_PRIME: begin
        cmd_o.prime = 1'b1;
        state_d     = ST_WALK;
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
        if (status_i.hit) begin
          state_d = ST_FRONT;
        end
      end
      ST_FRONT: begin
        // hold the result until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.front = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: src/mtf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_datapath
// Datapath: symbol list memory with per-entry valid bits, walk registers,
// mode register and output payload registers.
// ----------------------------------------------------------------------------
module mtf_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_wdata_i,
  input  logic [mtf_pkg::SYM_W-1:0]      symbol_in_i,
  input  logic                           last_entry_i,
  output logic [mtf_pkg::SYM_W-1:0]      symbol_out_o,
  output logic                           last_out_o,
  input  mtf_pkg::mtf_cmd_t              cmd_i,
  output mtf_pkg::mtf_status_t           status_o
);
  import mtf_pkg::*;

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(ALPHABET_SIZE - 1);
  localparam logic [SYM_W:0]   SatLim  = (SYM_W + 1)'(ALPHABET_SIZE);
  localparam logic [SYM_W-1:0] SatVal  = SYM_W'(ALPHABET_SIZE - 1);

  logic [SYM_W-1:0]         mem [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] valid_q;

  logic             mode_q;
  logic [SYM_W-1:0] sym_q, prev_q, rdata_q, value_q, res_q;
  logic             last_q, rvalid_q;
  logic [IDX_W-1:0] k_q;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [SYM_W-1:0] mem_wdata;
  logic [SYM_W-1:0] old;
  logic             hit;
  logic [SYM_W-1:0] sym_sat;

  assign sym_sat = ({1'b0, symbol_in_i} >= SatLim) ? SatVal : symbol_in_i;

  // entries never written since the last clear read as identity
  assign old = rvalid_q ? rdata_q : SYM_W'(k_q);
  assign hit = (mode_q ? (k_q == sym_q[IDX_W-1:0]) : (old == sym_q)) || (k_q == LastIdx);
  assign status_o.hit = hit;

  assign rd_en   = cmd_i.prime | (cmd_i.walk & ~hit);
  assign rd_addr = cmd_i.prime ? '0 : k_q + IDX_W'(1);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = k_q;
    mem_wdata = prev_q;
    if (cmd_i.walk && (k_q != '0)) begin
      mem_we = 1'b1;
    end else if (cmd_i.front && !last_q) begin
      mem_we    = 1'b1;
      mem_waddr = '0;
      mem_wdata = value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      mode_q  <= 1'b0;
    end else begin
      if (cmd_i.front && last_q) begin
        valid_q <= '0;
      end else if (mem_we) begin
        valid_q[mem_waddr] <= 1'b1;
      end
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sym_q  <= sym_sat;
      last_q <= last_entry_i;
    end
    if (rd_en) begin
      rvalid_q <= valid_q[rd_addr];
      k_q      <= rd_addr;
    end
    if (cmd_i.walk) begin
      prev_q <= old;
      if (hit) begin
        value_q <= mode_q ? old : sym_q;
        res_q   <= mode_q ? old : SYM_W'(k_q);
      end
    end
    if (cmd_i.front) begin
      symbol_out_o <= res_q;
      last_out_o   <= last_q;
    end
  end

endmodule

// File: src/move_to_front_byte_coder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_to_front_byte_coder
// Move-to-front transform over a 256-entry byte list, encode or decode.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries symbol_in_i and
//   last_entry_i; output channel (out_valid_o/out_ready_i) carries
//   symbol_out_o and last_out_o. Each transfer in gives one transfer out.
//   cfg_we_i/cfg_wdata_i set the mode (0 encode, 1 decode) while idle.
//   An item found at list position p passes through a prime step that
//   issues the first list read, a walk over list positions 0 to p that
//   reads the list memory one entry per cycle while shifting it, and a
//   front step that writes it to list position 0 unless it is the last entry.
//   Items are processed one at a time; the next input is taken in the
//   cycle after the front write, while the previous result may still
//   wait in the output register.
//   If the receiver stalls, the following result is held until the output
//   register frees. Reset clears the list to identity order at once (per
//   entry valid bits), as does an item marked as last entry.
// ----------------------------------------------------------------------------
module move_to_front_byte_coder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [mtf_pkg::SYM_W-1:0] symbol_in_i,
  input  logic                      last_entry_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [mtf_pkg::SYM_W-1:0] symbol_out_o,
  output logic                      last_out_o
);
  import mtf_pkg::*;

  mtf_cmd_t    cmd;
  mtf_status_t status;

  mtf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  mtf_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .symbol_in_i  (symbol_in_i),
    .last_entry_i (last_entry_i),
    .symbol_out_o (symbol_out_o),
    .last_out_o   (last_out_o),
    .cmd_i        (cmd),
    .status_o     (status)
  );

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for move_to_front_byte_coder. A local move-to-front
// list tracks every input transfer and predicts each output transfer.
// Directed items cover list extremes, symbols already at the front, mode
// changes inside a map and last-entry resets. Random maps follow under three
// valid/ready idling mixes.
// ----------------------------------------------------------------------------
module tb;

  import mtf_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned TAIL_CYCLES    = 300;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } coded_item_t;

  logic             clk_i      = 1'b0;
  logic             rst_ni     = 1'b0;
  logic             cfg_we     = 1'b0;
  logic             cfg_wdata  = 1'b0;
  logic             in_valid   = 1'b0;
  logic [SYM_W-1:0] symbol_in  = '0;
  logic             last_entry = 1'b0;
  logic             out_ready  = 1'b0;
  logic             in_ready;
  logic             out_valid;
  logic [SYM_W-1:0] symbol_out;
  logic             last_out;

  logic [SYM_W-1:0] coder_list [ALPHABET_SIZE];
  logic             decode_active = 1'b0;
  coded_item_t      expected_codes [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int unsigned encoded_count  = 0;
  int unsigned decoded_count  = 0;
  int unsigned maps_closed    = 0;
  int unsigned results_seen   = 0;

  move_to_front_byte_coder i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .symbol_in_i  (symbol_in),
    .last_entry_i (last_entry),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .symbol_out_o (symbol_out),
    .last_out_o   (last_out)
  );

  always #5 clk_i = ~clk_i;

  function automatic void list_identity();
    for (int k = 0; k < ALPHABET_SIZE; k++) coder_list[k] = k[SYM_W-1:0];
  endfunction

  function automatic coded_item_t mtf_code(input logic [SYM_W-1:0] sym, input logic last);
    int unsigned      sat;
    int unsigned      pos;
    logic [SYM_W-1:0] value;
    coded_item_t      res;
    sat = 32'(sym);
    pos = 0;
    if (sat >= ALPHABET_SIZE) sat = ALPHABET_SIZE - 1;
    if (decode_active) begin
      pos   = sat;
      value = coder_list[pos];
      res.symbol = value;
    end else begin
      value = sat[SYM_W-1:0];
      for (int k = ALPHABET_SIZE - 1; k >= 0; k--) begin
        if (coder_list[k] == value) pos = k;
      end
      res.symbol = pos[SYM_W-1:0];
    end
    for (int k = int'(pos); k > 0; k--) coder_list[k] = coder_list[k-1];
    coder_list[0] = value;
    res.last = last;
    if (last) list_identity();
    return res;
  endfunction

  initial list_identity();

  // track config writes and input transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we) decode_active = cfg_wdata;
      if (in_valid && in_ready) begin
        expected_codes.push_back(mtf_code(symbol_in, last_entry));
        if (decode_active) decoded_count++;
        else encoded_count++;
        if (last_entry) maps_closed++;
      end
    end
  end

  always @(posedge clk_i) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic report_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned got_v);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
    mismatch_count++;
  endtask

  // check output transfers against the oldest prediction
  always @(posedge clk_i) begin
    coded_item_t exp_item;
    if (rst_ni && out_valid && out_ready) begin
      results_seen++;
      if (expected_codes.size() == 0) begin
        report_mismatch("unexpected result, symbol", 0, 32'(symbol_out));
      end else begin
        exp_item = expected_codes.pop_front();
        if (symbol_out !== exp_item.symbol)
          report_mismatch("symbol_out", 32'(exp_item.symbol), 32'(symbol_out));
        if (last_out !== exp_item.last)
          report_mismatch("last_out", 32'(exp_item.last), 32'(last_out));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    symbol_in  <= sym;
    last_entry <= last;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_codes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic mode);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [SYM_W-1:0] random_symbol();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return SYM_W'($urandom_range(15));
    if (pick < 60) return ($urandom_range(1) != 0) ? {SYM_W{1'b1}} : {SYM_W{1'b0}};
    return SYM_W'($urandom_range(ALPHABET_SIZE - 1));
  endfunction

  task automatic test_encode_extremes();
    set_mode(1'b0);
    send_symbol(8'd0, 1'b0);
    send_symbol(8'd255, 1'b0);
    send_symbol(8'd255, 1'b0);
    send_symbol(8'd0, 1'b0);
    send_symbol(8'd128, 1'b1);
  endtask

  task automatic test_decode_extremes();
    set_mode(1'b1);
    send_symbol(8'd0, 1'b0);
    send_symbol(8'd255, 1'b0);
    send_symbol(8'd0, 1'b0);
    send_symbol(8'd1, 1'b0);
    send_symbol(8'd255, 1'b1);
  endtask

  // list must survive a mode change that lands inside a map
  task automatic test_mode_switch_in_map();
    set_mode(1'b0);
    send_symbol(8'd200, 1'b0);
    send_symbol(8'd17, 1'b0);
    set_mode(1'b1);
    send_symbol(8'd1, 1'b0);
    send_symbol(8'd0, 1'b0);
    send_symbol(8'd2, 1'b1);
    set_mode(1'b0);
    send_symbol(8'd200, 1'b0);
    send_symbol(8'd255, 1'b1);
  endtask

  task automatic test_last_entry_reset();
    send_symbol(8'd3, 1'b1);
    send_symbol(8'd3, 1'b1);
    send_symbol(8'd170, 1'b0);
    send_symbol(8'd85, 1'b1);
  endtask

  task automatic test_random_maps(input int unsigned n_items, input int unsigned send_pct,
                                  input int unsigned recv_pct);
    int unsigned sent;
    int unsigned map_len;
    bit          broken;
    logic        last;
    sent          = 0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (sent < n_items) begin
      if ($urandom_range(99) < 30) set_mode(1'($urandom_range(1)));
      map_len = $urandom_range(1, 40);
      broken  = ($urandom_range(9) == 0);
      for (int unsigned i = 0; i < map_len; i++) begin
        if (broken) last = ($urandom_range(15) == 0);
        else last = (i == map_len - 1);
        send_symbol(random_symbol(), last);
        sent++;
        if (i == map_len / 2 && $urandom_range(49) == 0) wait_drained();
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 36;
    recv_idle_pct = 61;
    test_encode_extremes();
    test_decode_extremes();
    test_mode_switch_in_map();
    test_last_entry_reset();

    test_random_maps(610, 36, 61);
    test_random_maps(610, 61, 36);
    test_random_maps(610, 0, 0);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_codes.size() != 0)
      report_mismatch("leftover predictions", 0, unsigned'(expected_codes.size()));

    $display("run covered %0d encode and %0d decode transfers, %0d closed maps",
             encoded_count, decoded_count, maps_closed);
    $display("%0d results checked, %0d mismatches", results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
